// ----- rtl/tird_pkg.sv -----
// Shared types and constants for the tape image record deframer.
// Holds the item structs, the token passed from front to back, and the code enums.
// No dependencies.
`default_nettype none

package tird_pkg;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_SKIP   = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    EV_DATA         = 3'd0,
    EV_MARK         = 3'd1,
    EV_END_LOGICAL  = 3'd2,
    EV_END_PHYSICAL = 3'd3,
    EV_BAD_LENGTH   = 3'd4
  } event_e;

  localparam logic [1:0]  FMT_STD = 2'd0;
  localparam logic [1:0]  FMT_E11 = 2'd1;
  localparam logic [1:0]  FMT_TPC = 2'd2;

  localparam logic        REG_FORMAT  = 1'b0;
  localparam logic        REG_MAX_LEN = 1'b1;

  localparam logic [30:0] MAX_LEN_RESET = 31'd65536;
  localparam logic [31:0] HDR_ALL_ONES  = 32'hFFFF_FFFF;
  localparam logic [15:0] FILE_MAX      = 16'hFFFF;
  localparam logic [23:0] REC_MAX       = 24'hFF_FFFF;
  localparam logic [2:0]  TRAILER_LEN   = 3'd4;

  typedef struct packed {
    logic       mode;
    logic [7:0] image_byte;
  } in_item_t;

  typedef struct packed {
    event_e      event_res;
    logic [7:0]  data_byte;
    logic [15:0] file_number;
    logic [23:0] record_number;
    logic        record_error;
    logic        last_of_record;
  } out_item_t;

  // Front-to-back token: one per classified byte that matters to the back end.
  typedef struct packed {
    logic       emit;   // produces a result item
    event_e     ev;
    logic       hdr;    // completed header: load the error flag from err
    logic       err;
    logic [7:0] data;
    logic       last;
  } token_t;

endpackage

`default_nettype wire

// ----- rtl/tird_front.sv -----
// Front end: accepts image bytes, assembles headers and classifies each byte.
// Holds the configuration registers. Depends on tird_pkg.
`default_nettype none

module tird_front import tird_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_index_i,
  input  wire logic [30:0] cfg_data_i,
  input  wire logic        in_valid_i,
  input  wire in_item_t    in_item_i,
  output logic             tok_push_o,
  output token_t           tok_o
);

  phase_e      phase_q, phase_d;
  logic [31:0] hdr_q, hdr_d;
  logic [1:0]  pos_q, pos_d;
  logic [30:0] left_q, left_d;
  logic [2:0]  skip_q, skip_d;
  logic        prev_mark_q, prev_mark_d;
  logic [1:0]  fmt_q;
  logic [30:0] max_len_q;

  logic        tpc, e11, hdr_end;
  logic [31:0] hv, len;
  logic [2:0]  skip_dec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q     <= FMT_STD;
      max_len_q <= MAX_LEN_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_FORMAT) begin
        fmt_q <= cfg_data_i[1:0];
      end else begin
        max_len_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      hdr_q       <= '0;
      pos_q       <= '0;
      left_q      <= '0;
      skip_q      <= '0;
      prev_mark_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      hdr_q       <= hdr_d;
      pos_q       <= pos_d;
      left_q      <= left_d;
      skip_q      <= skip_d;
      prev_mark_q <= prev_mark_d;
    end
  end

  always_comb begin
    tpc      = (fmt_q == FMT_TPC);
    e11      = (fmt_q == FMT_E11);
    hv       = hdr_q | (32'(in_item_i.image_byte) << {pos_q, 3'b000});
    hdr_end  = tpc ? (pos_q != 2'd0) : (pos_q == 2'd3);
    len      = tpc ? hv : {1'b0, hv[30:0]};
    skip_dec = skip_q - 3'(skip_q != 3'd0);

    phase_d     = phase_q;
    hdr_d       = hdr_q;
    pos_d       = pos_q;
    left_d      = left_q;
    skip_d      = skip_q;
    prev_mark_d = prev_mark_q;
    tok_push_o  = 1'b0;
    tok_o       = '{emit: 1'b0, ev: EV_DATA, hdr: 1'b0, err: 1'b0, data: 8'd0, last: 1'b0};

    if (in_valid_i && phase_q != PH_DONE) begin
      if (in_item_i.mode) begin
        // End of image: stop wherever we are.
        phase_d    = PH_DONE;
        tok_push_o = 1'b1;
        tok_o.emit = 1'b1;
        tok_o.ev   = EV_END_PHYSICAL;
      end else begin
        unique case (phase_q)
          PH_HEADER: begin
            if (!hdr_end) begin
              hdr_d = hv;
              pos_d = pos_q + 2'd1;
            end else begin
              hdr_d      = '0;
              pos_d      = '0;
              tok_push_o = 1'b1;
              tok_o.hdr  = 1'b1;
              tok_o.err  = !tpc && hv[31] && (hv != HDR_ALL_ONES);
              if (!tpc && hv == HDR_ALL_ONES) begin
                phase_d    = PH_DONE;
                tok_o.emit = 1'b1;
                tok_o.ev   = EV_END_PHYSICAL;
              end else if (len == 32'd0) begin
                tok_o.emit = 1'b1;
                if (prev_mark_q) begin
                  phase_d  = PH_DONE;
                  tok_o.ev = EV_END_LOGICAL;
                end else begin
                  prev_mark_d = 1'b1;
                  tok_o.ev    = EV_MARK;
                end
              end else if (len > {1'b0, max_len_q}) begin
                phase_d    = PH_DONE;
                tok_o.emit = 1'b1;
                tok_o.ev   = EV_BAD_LENGTH;
              end else begin
                // Record start: load counters, no result.
                prev_mark_d = 1'b0;
                left_d      = len[30:0];
                if (e11) begin
                  skip_d = TRAILER_LEN;
                end else if (tpc) begin
                  skip_d = {2'b00, len[0]};
                end else begin
                  skip_d = TRAILER_LEN + {2'b00, len[0]};
                end
                phase_d = PH_DATA;
              end
            end
          end
          PH_DATA: begin
            tok_push_o = 1'b1;
            tok_o.emit = 1'b1;
            tok_o.ev   = EV_DATA;
            tok_o.data = in_item_i.image_byte;
            tok_o.last = (left_q <= 31'd1);
            if (left_q <= 31'd1) begin
              left_d  = '0;
              phase_d = (skip_q != 3'd0) ? PH_SKIP : PH_HEADER;
            end else begin
              left_d = left_q - 31'd1;
            end
          end
          PH_SKIP: begin
            skip_d = skip_dec;
            if (skip_dec == 3'd0) begin
              phase_d = PH_HEADER;
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end
  end

`ifndef ASSERT_OFF
  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DONE |-> !tok_push_o)
    else $error("token produced after terminal event");
  a_hdr_no_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HEADER |-> left_q == 31'd0)
    else $error("data count left over in header phase");
`endif

endmodule

`default_nettype wire

// ----- rtl/tird_fifo.sv -----
// Short token queue between the front and back ends.
// Register-based, one write and one read port. Depends on tird_pkg.
`default_nettype none

module tird_fifo import tird_pkg::*; #(
  parameter int Depth = 2
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire token_t data_i,
  input  wire logic   pop_i,
  output logic        full_o,
  output logic        valid_o,
  output token_t      data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  token_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

// ----- rtl/tird_back.sv -----
// Back end: tracks file, record and error state and builds result items.
// Drives the output register. Depends on tird_pkg.
`default_nettype none

module tird_back import tird_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   tok_valid_i,
  input  wire token_t tok_i,
  output logic        tok_pop_o,
  input  wire logic   pop_i,
  output logic        empty_o,
  output out_item_t   out_item_o
);

  logic [15:0] file_q;
  logic [23:0] rec_q;
  logic        err_q;
  logic        out_valid_q;
  out_item_t   out_q;
  logic        err_now;

  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;
  assign tok_pop_o  = tok_valid_i && (!out_valid_q || pop_i);
  assign err_now    = tok_i.hdr ? tok_i.err : err_q;

  always_ff @(posedge clk_i) begin
    if (tok_pop_o) begin
      out_q.event_res      <= tok_i.ev;
      out_q.data_byte      <= tok_i.data;
      out_q.file_number    <= file_q;
      out_q.record_number  <= rec_q;
      out_q.record_error   <= err_now;
      out_q.last_of_record <= tok_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_q      <= 16'd1;
      rec_q       <= 24'd1;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (tok_pop_o) begin
        out_valid_q <= tok_i.emit;
        err_q       <= err_now;
        if (tok_i.emit && tok_i.ev == EV_DATA && tok_i.last && rec_q != REC_MAX) begin
          rec_q <= rec_q + 24'd1;
        end
        if (tok_i.emit && tok_i.ev == EV_MARK) begin
          rec_q <= 24'd1;
          if (file_q != FILE_MAX) begin
            file_q <= file_q + 16'd1;
          end
        end
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_counts_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    file_q != 16'd0 && rec_q != 24'd0)
    else $error("file or record counter wrapped to zero");
  a_mark_resets_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_pop_o && tok_i.emit && tok_i.ev == EV_MARK |=> rec_q == 24'd1)
    else $error("record counter not restarted after tape mark");
`endif

endmodule

`default_nettype wire

// ----- rtl/tape_image_record_deframer.sv -----
// Top level of the tape image record deframer.
// Instantiates tird_front, tird_fifo and tird_back; depends on tird_pkg.
//
// Usage:
//   Input channel (push/full): one item per accepted cycle, either an
//   image byte (mode 0) or the end-of-image marker (mode 1). Items are taken
//   whenever push is high and full is low, one per cycle sustained.
//   Result channel (empty/pop): the oldest result sits on out_item_o while
//   empty is low and leaves on a cycle with pop high. Header, pad and
//   trailer bytes give no result; data bytes and tape events give one each.
//   The edge that accepts an item writes its token into the token queue;
//   the output register loads it once that register is free or popped.
//   Throughput: one item per cycle unless the receiver stalls; the front end
//   classifies combinationally and the back end retires a token per cycle.
//   Stall: when the receiver stops popping, the output register holds and
//   the token queue (QueueDepth entries) fills, then full rises.
//   Config (cfg_valid_i/cfg_ready_o): always ready; index 0 is the image
//   format, index 1 the maximum record length. Write only while idle.
//   Reset: standard format, maximum length 65536, file and record number one.
//   After a terminal event input is still taken but dropped until reset.
`default_nettype none

module tape_image_record_deframer import tird_pkg::*; #(
  parameter int QueueDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [30:0] cfg_data_i,
  input  wire logic        push,
  output logic             full,
  input  wire in_item_t    in_item_i,
  output logic             empty,
  input  wire logic        pop,
  output out_item_t        out_item_o
);

  logic   accept;
  logic   tok_push, tok_pop, tok_valid;
  token_t tok_in, tok_out;

  // Configuration is taken every cycle.
  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  tird_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (accept),
    .in_item_i   (in_item_i),
    .tok_push_o  (tok_push),
    .tok_o       (tok_in)
  );

  // Decouple classification from result building.
  tird_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (tok_push),
    .data_i  (tok_in),
    .pop_i   (tok_pop),
    .full_o  (full),
    .valid_o (tok_valid),
    .data_o  (tok_out)
  );

  tird_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_valid),
    .tok_i       (tok_out),
    .tok_pop_o   (tok_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ----- dv/tb_tape_image_record_deframer.sv -----
// Testbench for the tape image record deframer: drives tape image bytes through
// the queue-style ports and checks every result item against a local predictor.
// Depends on tird_pkg and tape_image_record_deframer.
`default_nettype none

module tb_tape_image_record_deframer;
  import tird_pkg::*;

  localparam logic [1:0]  FMT_UNUSED = 2'd3;   // undefined code, decodes as standard
  localparam logic [31:0] ERR_BIT    = 32'h8000_0000;
  localparam int          MaxGap     = 14;

  // How the run is closed. Only one terminal event fits in a run, since reset
  // is applied once; the simulator seed picks which one.
  typedef enum int {
    END_IN_HEADER,
    END_IN_DATA,
    END_IN_SKIP,
    END_AT_BOUNDARY,
    ALL_ONES_HEADER,
    DOUBLE_MARK,
    LENGTH_TOO_LONG,
    ZERO_LIMIT
  } ending_e;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [30:0] cfg_data_i;
  logic        push;
  logic        full;
  in_item_t    in_item_i;
  logic        empty;
  logic        pop;
  out_item_t   out_item_o;

  tape_image_record_deframer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Predictor copy of the register file and the deframer state.
  logic [1:0]  cfg_format;
  logic [30:0] max_len;
  phase_e      dec_phase;
  logic [31:0] hdr_acc;
  logic [1:0]  hdr_count;
  logic [30:0] data_left;
  logic [2:0]  skip_left;
  logic        after_mark;
  logic [15:0] file_no;
  logic [23:0] rec_no;
  logic        err_flag;

  out_item_t predicted_events[$];

  bit      sender_gaps;
  bit      receiver_gaps;
  int      pop_wait;
  int      bytes_sent;
  int      events_checked;
  int      reg_writes;
  int      mismatches;
  ending_e ending;

  // Pad plus trailer that follow a record of this length in the current layout.
  function automatic int trailer_bytes(logic [31:0] len);
    if (cfg_format == FMT_E11) return 4;
    if (cfg_format == FMT_TPC) return int'(len[0]);
    return 4 + int'(len[0]);
  endfunction

  // Favor the byte extremes.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic post_event(event_e ev, logic [7:0] b, logic is_last);
    out_item_t r;
    r.event_res      = ev;
    r.data_byte      = b;
    r.file_number    = file_no;
    r.record_number  = rec_no;
    r.record_error   = err_flag;
    r.last_of_record = is_last;
    predicted_events.push_back(r);
  endtask

  // Advance the predictor by one accepted item and queue the result it causes.
  task automatic deframe_byte(in_item_t it);
    logic [31:0] len;
    int          size;
    logic        is_last;
    if (dec_phase == PH_DONE) return;   // drop everything after a terminal event
    if (it.mode) begin
      dec_phase = PH_DONE;
      post_event(EV_END_PHYSICAL, 8'h00, 1'b0);
      return;
    end
    case (dec_phase)
      PH_HEADER: begin
        size = (cfg_format == FMT_TPC) ? 2 : 4;
        hdr_acc |= 32'(it.image_byte) << (8 * hdr_count);
        if (int'(hdr_count) + 1 < size) begin
          hdr_count++;
        end else begin
          len       = hdr_acc;
          hdr_acc   = '0;
          hdr_count = '0;
          err_flag  = 1'b0;
          if (cfg_format != FMT_TPC && len == HDR_ALL_ONES) begin
            dec_phase = PH_DONE;
            post_event(EV_END_PHYSICAL, 8'h00, 1'b0);
          end else begin
            // Strip the error marker; what remains may still be a tape mark.
            if (cfg_format != FMT_TPC && len[31]) begin
              err_flag = 1'b1;
              len[31]  = 1'b0;
            end
            if (len == '0) begin
              if (after_mark) begin
                dec_phase = PH_DONE;
                post_event(EV_END_LOGICAL, 8'h00, 1'b0);
              end else begin
                after_mark = 1'b1;
                post_event(EV_MARK, 8'h00, 1'b0);
                if (file_no != FILE_MAX) file_no++;
                rec_no = 24'd1;
              end
            end else if (len > {1'b0, max_len}) begin
              dec_phase = PH_DONE;
              post_event(EV_BAD_LENGTH, 8'h00, 1'b0);
            end else begin
              after_mark = 1'b0;
              data_left  = len[30:0];
              skip_left  = 3'(trailer_bytes(len));
              dec_phase  = PH_DATA;
            end
          end
        end
      end
      PH_DATA: begin
        is_last = (data_left <= 31'd1);
        post_event(EV_DATA, it.image_byte, is_last);
        if (is_last) begin
          data_left = '0;
          if (rec_no != REC_MAX) rec_no++;
          dec_phase = (skip_left != '0) ? PH_SKIP : PH_HEADER;
        end else begin
          data_left--;
        end
      end
      default: begin
        if (skip_left != '0) skip_left--;
        if (skip_left == '0) dec_phase = PH_HEADER;
      end
    endcase
  endtask

  // Offer one item after a random gap; hold push high on return so that
  // back-to-back items keep the input side busy.
  task automatic send_item(logic m, logic [7:0] b);
    in_item_t it;
    int       gap;
    it.mode       = m;
    it.image_byte = b;
    gap = sender_gaps ? $urandom_range(0, MaxGap) : 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push      <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (full);
    bytes_sent++;
    deframe_byte(it);
  endtask

  task automatic send_header(logic [31:0] value);
    int n;
    n = (cfg_format == FMT_TPC) ? 2 : 4;
    for (int i = 0; i < n; i++) send_item(1'b0, value[8*i +: 8]);
  endtask

  task automatic send_mark(logic err);
    send_header((err && cfg_format != FMT_TPC) ? ERR_BIT : 32'h0);
  endtask

  // A whole record: header, data (fixed fill, or random when fill < 0), pad and trailer.
  task automatic send_record(int len, logic err, int fill);
    logic [31:0] hdr;
    hdr = 32'(len);
    if (err && cfg_format != FMT_TPC) hdr |= ERR_BIT;
    send_header(hdr);
    for (int i = 0; i < len; i++) send_item(1'b0, (fill < 0) ? pick_byte() : 8'(fill));
    repeat (trailer_bytes(hdr)) send_item(1'b0, 8'($urandom));
  endtask

  // Hold off the input until every predicted result is out, then let any
  // in-flight header token retire (it gives no result of its own).
  task automatic drain_and_settle();
    push <= 1'b0;
    while (predicted_events.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Write both registers back to back; call only while idle.
  task automatic set_config(logic [1:0] fmt, logic [30:0] limit);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_FORMAT;
    cfg_data_i  <= 31'(fmt);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_format = fmt;
    cfg_index_i <= REG_MAX_LEN;
    cfg_data_i  <= limit;
    do @(posedge clk_i); while (!cfg_ready_o);
    max_len = limit;
    cfg_valid_i <= 1'b0;
    reg_writes += 2;
  endtask

  // Reset settings: odd record with pad, a mark carrying the error bit,
  // then an even record carrying the error bit.
  task automatic test_reset_layout();
    send_record(1, 1'b0, 8'hFF);
    send_mark(1'b1);
    send_record(2, 1'b1, 8'h00);
  endtask

  // Limit at both extremes; a record exactly at the limit.
  task automatic test_register_extremes();
    drain_and_settle();
    set_config(FMT_E11, 31'h7FFF_FFFF);
    send_record(1, 1'b0, -1);
    drain_and_settle();
    set_config(FMT_TPC, 31'd1);
    send_record(1, 1'b1, -1);
  endtask

  // Mostly well-formed records and single marks with random content, in
  // several layouts and limits. Drain now and then to empty the pipeline.
  task automatic test_random_stream();
    logic [1:0]  fmt;
    logic [30:0] limit;
    int          start;
    int          cap;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       begin fmt = FMT_STD;    limit = MAX_LEN_RESET; end
        1:       begin fmt = FMT_E11;    limit = 31'h7FFF_FFFF; end
        2:       begin fmt = FMT_TPC;    limit = 31'd1; end
        3:       begin fmt = FMT_UNUSED; limit = 31'($urandom_range(1, 40)); end
        4:       begin fmt = FMT_TPC;    limit = 31'($urandom_range(1, 40)); end
        default: begin fmt = 2'($urandom_range(0, 3)); limit = 31'($urandom_range(2, 70)); end
      endcase
      drain_and_settle();
      set_config(fmt, limit);
      start = bytes_sent;
      while (bytes_sent - start < 160) begin
        sender_gaps   = ($urandom_range(0, 3) != 0);
        receiver_gaps = ($urandom_range(0, 3) != 0);
        if (!after_mark && $urandom_range(0, 5) == 0) begin
          send_mark($urandom_range(0, 3) == 0);
        end else begin
          cap = (max_len < 31'd24) ? int'(max_len) : 24;
          if ($urandom_range(0, 9) == 0) cap = (max_len < 31'd64) ? int'(max_len) : 64;
          send_record($urandom_range(1, cap), $urandom_range(0, 3) == 0, -1);
        end
        if ($urandom_range(0, 24) == 0) drain_and_settle();
      end
    end
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
  endtask

  // Shortest TPC files (one 2-byte record plus a mark) at full rate on both
  // sides, so header, data and mark tokens follow each other closely.
  task automatic test_back_to_back_files();
    drain_and_settle();
    set_config(FMT_TPC, MAX_LEN_RESET);
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    for (int f = 0; f < 10; f++) begin
      send_record(2, 1'b0, -1);
      send_mark(1'b0);
    end
    send_record(1, 1'b0, -1);
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
  endtask

  // Close the tape one way, then check that later items, end-of-image too,
  // give nothing.
  task automatic test_terminal_event();
    logic [1:0]  fmt;
    logic [30:0] limit;
    drain_and_settle();
    ending = ending_e'($urandom_range(0, 7));
    fmt    = 2'($urandom_range(0, 3));
    limit  = MAX_LEN_RESET;
    if (ending == ALL_ONES_HEADER && fmt == FMT_TPC) fmt = FMT_STD;
    if (ending == LENGTH_TOO_LONG) limit = 31'($urandom_range(1, 100));
    if (ending == ZERO_LIMIT) limit = '0;
    set_config(fmt, limit);
    case (ending)
      END_IN_HEADER: begin
        send_item(1'b0, 8'($urandom));
        send_item(1'b1, 8'($urandom));
      end
      END_IN_DATA: begin
        send_header(32'd6);
        repeat (3) send_item(1'b0, pick_byte());
        send_item(1'b1, 8'($urandom));
      end
      END_IN_SKIP: begin
        // Stop one byte short of the end of the pad and trailer.
        send_header(32'd3);
        repeat (3) send_item(1'b0, pick_byte());
        repeat (trailer_bytes(32'd3) - 1) send_item(1'b0, 8'($urandom));
        send_item(1'b1, 8'($urandom));
      end
      END_AT_BOUNDARY: send_item(1'b1, 8'($urandom));
      ALL_ONES_HEADER: send_header(HDR_ALL_ONES);
      DOUBLE_MARK: begin
        send_mark(1'b0);
        send_mark(1'($urandom_range(0, 1)));
      end
      LENGTH_TOO_LONG: send_header(32'(limit) + 32'd1);
      default:         send_header(32'($urandom_range(1, 300)));
    endcase
    for (int i = 0; i < 16; i++) begin
      send_item(i == 3 || $urandom_range(0, 3) == 0, 8'($urandom));
    end
  endtask

  // Result side: pop after a random stall per item and compare each accepted
  // item with the oldest prediction.
  always @(posedge clk_i) begin
    out_item_t want;
    if (pop && !empty) begin
      if (predicted_events.size() == 0) begin
        $error("unpredicted result item: event_res %0d", out_item_o.event_res);
        mismatches++;
      end else begin
        want = predicted_events.pop_front();
        events_checked++;
        if (out_item_o.event_res != want.event_res) begin
          $error("event_res: expected %0d, got %0d", want.event_res, out_item_o.event_res);
          mismatches++;
        end
        if (out_item_o.data_byte != want.data_byte) begin
          $error("data_byte: expected %0d, got %0d", want.data_byte, out_item_o.data_byte);
          mismatches++;
        end
        if (out_item_o.file_number != want.file_number) begin
          $error("file_number: expected %0d, got %0d",
                 want.file_number, out_item_o.file_number);
          mismatches++;
        end
        if (out_item_o.record_number != want.record_number) begin
          $error("record_number: expected %0d, got %0d",
                 want.record_number, out_item_o.record_number);
          mismatches++;
        end
        if (out_item_o.record_error != want.record_error) begin
          $error("record_error: expected %0d, got %0d",
                 want.record_error, out_item_o.record_error);
          mismatches++;
        end
        if (out_item_o.last_of_record != want.last_of_record) begin
          $error("last_of_record: expected %0d, got %0d",
                 want.last_of_record, out_item_o.last_of_record);
          mismatches++;
        end
      end
      pop_wait = receiver_gaps ? $urandom_range(0, MaxGap) : 0;
    end
    if (pop_wait != 0) begin
      pop <= 1'b0;
      pop_wait--;
    end else begin
      pop <= 1'b1;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    push        = 1'b0;
    pop         = 1'b0;
    in_item_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_FORMAT;
    cfg_data_i  = '0;

    cfg_format = FMT_STD;
    max_len    = MAX_LEN_RESET;
    dec_phase  = PH_HEADER;
    hdr_acc    = '0;
    hdr_count  = '0;
    data_left  = '0;
    skip_left  = '0;
    after_mark = 1'b0;
    file_no    = 16'd1;
    rec_no     = 24'd1;
    err_flag   = 1'b0;

    sender_gaps    = 1'b1;
    receiver_gaps  = 1'b1;
    pop_wait       = 0;
    bytes_sent     = 0;
    events_checked = 0;
    reg_writes     = 0;
    mismatches     = 0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_layout();
    test_register_extremes();
    test_random_stream();
    test_back_to_back_files();
    test_terminal_event();

    drain_and_settle();
    repeat (10) @(posedge clk_i);

    $display("Sent %0d tape image items, checked %0d result items, made %0d register writes.",
             bytes_sent, events_checked, reg_writes);
    $display("Covered all layouts, back-to-back short files; tape closed by %s.",
             ending.name());
    if (mismatches == 0) begin
      $display("PASS tape_image_record_deframer");
    end else begin
      $display("FAIL tape_image_record_deframer");
    end
    $finish;
  end

  // Hang guard: report a failure and stop if the run has not finished by the timeout,
  // even with the longest gaps on both sides.
  initial begin
    #5_000_000;
    $display("FAIL tape_image_record_deframer");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/tird_pkg.sv
rtl/tird_front.sv
rtl/tird_fifo.sv
rtl/tird_back.sv
rtl/tape_image_record_deframer.sv
dv/tb_tape_image_record_deframer.sv
